@@ sv/tofp_pkg.sv @@
// Shared types and constants for the time-of-flight sensor frame parser.
// No dependencies; used by tofp_frame_acc and tof_sensor_frame_parser_unit.
package tofp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 5;

    // Frame layout.
    localparam logic [BYTE_W-1:0]  HDR0          = 8'h5A;
    localparam logic [BYTE_W-1:0]  HDR1          = 8'h8E;
    localparam logic [BYTE_W-1:0]  HDR2          = 8'h17;
    localparam logic [COUNT_W-1:0] POS_HDR0      = 5'd0;
    localparam logic [COUNT_W-1:0] POS_HDR1      = 5'd1;
    localparam logic [COUNT_W-1:0] POS_HDR2      = 5'd2;
    localparam logic [COUNT_W-1:0] PAYLOAD_FIRST = 5'd3;
    localparam logic [COUNT_W-1:0] CSUM_POS      = 5'd26;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 5'd31;
    localparam int unsigned        PAYLOAD_DEPTH = 23;
    localparam int unsigned        IDX_W         = $clog2(PAYLOAD_DEPTH);

    // Decoded fields. Packed with the last member in the lowest bits, so the
    // whole struct is the output word with tof_main at bit 0.
    typedef struct packed {
        logic        [7:0]  confidence;
        logic signed [15:0] calibrated_distance;
        logic signed [31:0] temperature;
        logic        [15:0] ref_tof;
        logic        [23:0] noise_att;
        logic        [15:0] peak_att;
        logic        [15:0] shot_count;
        logic        [23:0] noise_main;
        logic        [15:0] peak_main;
        logic        [15:0] tof_main;
    } t_frame_fields;

    localparam int unsigned TDATA_W = $bits(t_frame_fields);

    typedef struct packed {
        logic          frame_ok;
        t_frame_fields fields;
    } t_frame_result;

endpackage

@@ sv/tofp_frame_acc.sv @@
// Per-byte frame accumulator: byte count, running sum, header and checksum
// flags and payload registers, plus the decode of a finished frame.
// Depends on tofp_pkg.
module tofp_frame_acc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [tofp_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_last,
    output logic                         o_res_valid,
    output tofp_pkg::t_frame_result      o_res
);

    logic [tofp_pkg::COUNT_W-1:0] r_count;
    logic [tofp_pkg::BYTE_W-1:0]  r_sum;
    logic                         r_hdr_ok;
    logic                         r_csum_ok;
    logic [tofp_pkg::BYTE_W-1:0]  r_payload [tofp_pkg::PAYLOAD_DEPTH];

    logic [tofp_pkg::COUNT_W-1:0] n_count;
    logic [tofp_pkg::BYTE_W-1:0]  n_sum;
    logic                         n_hdr_ok;
    logic                         n_csum_ok;
    logic [tofp_pkg::IDX_W-1:0]   w_idx;
    logic                         w_store;
    logic                         w_hdr_bad;
    logic                         w_ok;

    assign w_idx   = tofp_pkg::IDX_W'(r_count - tofp_pkg::PAYLOAD_FIRST);
    assign w_store = (r_count >= tofp_pkg::PAYLOAD_FIRST) && (r_count < tofp_pkg::CSUM_POS);

    always_comb begin
        w_hdr_bad = ((r_count == tofp_pkg::POS_HDR0) && (i_byte != tofp_pkg::HDR0))
                 || ((r_count == tofp_pkg::POS_HDR1) && (i_byte != tofp_pkg::HDR1))
                 || ((r_count == tofp_pkg::POS_HDR2) && (i_byte != tofp_pkg::HDR2));
        n_hdr_ok  = r_hdr_ok && !w_hdr_bad;
        n_csum_ok = (r_count == tofp_pkg::CSUM_POS) ? (i_byte == r_sum) : r_csum_ok;
        n_sum     = (r_count < tofp_pkg::CSUM_POS) ? r_sum + i_byte : r_sum;
        n_count   = (r_count < tofp_pkg::COUNT_MAX) ? r_count + 5'd1 : r_count;
        // Only the byte at the checksum position can end a good frame.
        w_ok      = (r_count == tofp_pkg::CSUM_POS) && n_hdr_ok && n_csum_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_hdr_ok  <= 1'b1;
            r_csum_ok <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_count   <= '0;
                r_sum     <= '0;
                r_hdr_ok  <= 1'b1;
                r_csum_ok <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_sum     <= n_sum;
                r_hdr_ok  <= n_hdr_ok;
                r_csum_ok <= n_csum_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_store) begin
            r_payload[w_idx] <= i_byte;
        end
    end

    assign o_res_valid = i_accept && i_last;

    always_comb begin
        o_res = '0;
        if (w_ok) begin
            o_res.frame_ok                   = 1'b1;
            o_res.fields.tof_main            = {r_payload[1], r_payload[0]};
            o_res.fields.peak_main           = {r_payload[3], r_payload[2]};
            o_res.fields.noise_main          = {r_payload[6], r_payload[5], r_payload[4]};
            o_res.fields.shot_count          = {r_payload[8], r_payload[7]};
            o_res.fields.peak_att            = {r_payload[10], r_payload[9]};
            o_res.fields.noise_att           = {r_payload[13], r_payload[12], r_payload[11]};
            o_res.fields.ref_tof             = {r_payload[15], r_payload[14]};
            o_res.fields.temperature         = {r_payload[19], r_payload[18],
                                                r_payload[17], r_payload[16]};
            o_res.fields.calibrated_distance = {r_payload[21], r_payload[20]};
            o_res.fields.confidence          = r_payload[22];
        end
    end

endmodule

@@ sv/tof_sensor_frame_parser_unit.sv @@
// Time-of-flight sensor frame parser, top level.
// Takes one received byte per word on the input stream and hands one decoded
// result word per frame to the output stream.
//
// Input channel: i_s_tdata carries one frame byte, i_s_tlast marks the last
// byte of a frame. Output channel: o_m_tdata carries the ten decoded fields,
// o_m_tuser carries frame_ok. One output word follows every input word with
// tlast set; a frame is good only if it is 27 bytes long, starts 5A 8E 17 and
// its last byte equals the 8-bit sum of the bytes before it. A bad frame gives
// a word with frame_ok low and all fields zero.
// Throughput is one byte per cycle while o_s_tready is high; each result is
// registered in the output register. All per-byte work is a compare, an 8-bit
// add and a register write between the state registers and the output register.
// Reset clears the byte count, sum and flags and empties the output stage; the
// payload registers are not cleared, as each good frame rewrites all of them.
// When the receiver stalls, one result waits in the output register and a
// second in a skid register; o_s_tready falls only while the skid is occupied.
module tof_sensor_frame_parser_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,  // [7:0] data_byte
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [15:0] tof_main, [31:16] peak_main, [55:32] noise_main, [71:56] shot_count,
    // [87:72] peak_att, [111:88] noise_att, [127:112] ref_tof,
    // [159:128] temperature, [175:160] calibrated_distance, [183:176] confidence
    output logic [tofp_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic                           o_m_tuser   // [0] frame_ok
);

    logic                    w_accept;
    logic                    w_res_valid;
    tofp_pkg::t_frame_result w_res;

    logic                    r_out_valid;
    tofp_pkg::t_frame_result r_out;
    logic                    r_skid_valid;
    tofp_pkg::t_frame_result r_skid;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    tofp_frame_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output register with a one-word skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_m_tready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= w_res_valid;
                end
            end else if (w_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_res_valid) begin
                r_out <= w_res;
            end
        end else if (w_res_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.fields;
    assign o_m_tuser  = r_out.frame_ok;

endmodule

@@ dv/tof_frame_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the time-of-flight frame parser: watches both stream channels,
// predicts one result word per frame and compares it field by field.
// Depends on tofp_pkg for the result layout and the frame constants.
module tof_frame_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [7:0]                   i_s_tdata,   // [7:0] data_byte
    input  logic                         i_s_tlast,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [tofp_pkg::TDATA_W-1:0] i_m_tdata,   // decoded fields, tof_main lowest
    input  logic                         i_m_tuser,   // [0] frame_ok
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_results_seen,
    output int                           o_good_seen
);

    // Predicted receive state of the current frame.
    logic [4:0] rx_count;
    logic [7:0] rx_sum;
    logic       hdr_match;
    logic       csum_match;
    logic [7:0] payload [0:tofp_pkg::PAYLOAD_DEPTH-1];

    tofp_pkg::t_frame_result pending_frame_results [$];
    int fails;
    int seen;
    int good;

    initial begin
        fails = 0;
        seen  = 0;
        good  = 0;
    end

    // Little-endian read of n stored bytes starting at frame position first.
    function automatic logic [31:0] le_bytes(input int first, input int n);
        logic [31:0] v;
        int k;
        v = '0;
        for (k = 0; k < n; k++) begin
            v = v | (32'(payload[first - tofp_pkg::PAYLOAD_FIRST + k]) << (8 * k));
        end
        return v;
    endfunction

    task automatic clear_frame_state();
        rx_count   = '0;
        rx_sum     = '0;
        hdr_match  = 1'b1;
        csum_match = 1'b0;
    endtask

    task automatic predict_frame_byte(input logic [7:0] b, input logic last);
        tofp_pkg::t_frame_result r;
        logic [4:0] pos;
        pos = rx_count;
        if (pos == tofp_pkg::POS_HDR0 && b != tofp_pkg::HDR0) hdr_match = 1'b0;
        if (pos == tofp_pkg::POS_HDR1 && b != tofp_pkg::HDR1) hdr_match = 1'b0;
        if (pos == tofp_pkg::POS_HDR2 && b != tofp_pkg::HDR2) hdr_match = 1'b0;
        if (pos >= tofp_pkg::PAYLOAD_FIRST && pos < tofp_pkg::CSUM_POS)
            payload[pos - tofp_pkg::PAYLOAD_FIRST] = b;
        if (pos == tofp_pkg::CSUM_POS) csum_match = (b == rx_sum);
        if (pos < tofp_pkg::CSUM_POS) rx_sum = rx_sum + b;
        if (rx_count < tofp_pkg::COUNT_MAX) rx_count = rx_count + 5'd1;
        if (last) begin
            r = '0;
            // A 27-byte frame ends with the checksum byte at position 26.
            if (pos == tofp_pkg::CSUM_POS && hdr_match && csum_match) begin
                r.frame_ok                   = 1'b1;
                r.fields.tof_main            = 16'(le_bytes(3, 2));
                r.fields.peak_main           = 16'(le_bytes(5, 2));
                r.fields.noise_main          = 24'(le_bytes(7, 3));
                r.fields.shot_count          = 16'(le_bytes(10, 2));
                r.fields.peak_att            = 16'(le_bytes(12, 2));
                r.fields.noise_att           = 24'(le_bytes(14, 3));
                r.fields.ref_tof             = 16'(le_bytes(17, 2));
                r.fields.temperature         = le_bytes(19, 4);
                r.fields.calibrated_distance = 16'(le_bytes(23, 2));
                r.fields.confidence          = 8'(le_bytes(25, 1));
            end
            pending_frame_results.push_back(r);
            clear_frame_state();
        end
    endtask

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result_word(input logic [tofp_pkg::TDATA_W-1:0] data,
                                     input logic ok);
        tofp_pkg::t_frame_result want;
        tofp_pkg::t_frame_fields got;
        got = data;
        seen++;
        if (ok === 1'b1) good++;
        if (pending_frame_results.size() == 0) begin
            $error("result word arrived with no frame pending");
            fails++;
        end else begin
            want = pending_frame_results.pop_front();
            match_field("frame_ok", 32'(want.frame_ok), 32'(ok));
            match_field("tof_main", 32'(want.fields.tof_main), 32'(got.tof_main));
            match_field("peak_main", 32'(want.fields.peak_main), 32'(got.peak_main));
            match_field("noise_main", 32'(want.fields.noise_main), 32'(got.noise_main));
            match_field("shot_count", 32'(want.fields.shot_count), 32'(got.shot_count));
            match_field("peak_att", 32'(want.fields.peak_att), 32'(got.peak_att));
            match_field("noise_att", 32'(want.fields.noise_att), 32'(got.noise_att));
            match_field("ref_tof", 32'(want.fields.ref_tof), 32'(got.ref_tof));
            match_field("temperature", want.fields.temperature, got.temperature);
            match_field("calibrated_distance", 32'(want.fields.calibrated_distance),
                        32'(got.calibrated_distance));
            match_field("confidence", 32'(want.fields.confidence), 32'(got.confidence));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame_state();
        end else begin
            // A result never leaves in the cycle its last byte is taken, so the
            // output side is checked first.
            if (i_m_tvalid && i_m_tready) check_result_word(i_m_tdata, i_m_tuser);
            if (i_s_tvalid && i_s_tready) predict_frame_byte(i_s_tdata, i_s_tlast);
        end
        o_fail_count   <= fails;
        o_pending      <= pending_frame_results.size();
        o_results_seen <= seen;
        o_good_seen    <= good;
    end

endmodule

@@ dv/tb_tof_sensor_frame_parser_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for tof_sensor_frame_parser_unit: builds well-formed and broken
// sensor frames, drives them with random gaps and stalls, and gives the verdict.
// Depends on tofp_pkg, the block and tof_frame_checker.
module tb_tof_sensor_frame_parser_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BYTE_BUDGET = 1200;

    typedef enum int {FLAW_NONE, FLAW_HEADER, FLAW_CHECKSUM, FLAW_NOISE} t_flaw;
    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_EDGE} t_fill;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [7:0]                   i_s_tdata;   // [7:0] data_byte
    logic                         i_s_tlast;
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [tofp_pkg::TDATA_W-1:0] o_m_tdata;   // decoded fields, tof_main lowest
    logic                         o_m_tuser;   // [0] frame_ok

    int fail_count;
    int pending;
    int results_seen;
    int good_seen;
    int bytes_sent;
    int frames_sent;
    int well_formed;
    int cycle_count;
    logic quiet;

    tof_sensor_frame_parser_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    tof_frame_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tlast      (i_s_tlast),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_m_tuser      (o_m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_good_seen    (good_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] fill_byte(input t_fill fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_EDGE: begin
                case ($urandom_range(0, 4))
                    0: return 8'h00;
                    1: return 8'hFF;
                    2: return 8'h80;
                    3: return 8'h7F;
                    default: return 8'($urandom_range(0, 255));
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_fill pick_fill();
        case ($urandom_range(0, 7))
            0: return FILL_ZERO;
            1: return FILL_ONES;
            2, 3: return FILL_EDGE;
            default: return FILL_RAND;
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays high across back-to-back words.
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = b;
        i_s_tlast  = last;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int len, input t_flaw flaw, input t_fill fill,
                              input int hdr_pos);
        logic [7:0] fb [0:63];
        logic [7:0] sum;
        logic [7:0] flip;
        int i;
        sum  = '0;
        flip = 8'($urandom_range(1, 255));
        for (i = 0; i < 64; i++) fb[i] = 8'($urandom_range(0, 255));
        if (flaw != FLAW_NOISE) begin
            fb[0] = tofp_pkg::HDR0;
            fb[1] = tofp_pkg::HDR1;
            fb[2] = tofp_pkg::HDR2;
            for (i = 3; i < 26; i++) fb[i] = fill_byte(fill);
            for (i = 0; i < 26; i++) sum = sum + fb[i];
            fb[26] = sum;
            if (flaw == FLAW_HEADER) fb[hdr_pos] = fb[hdr_pos] ^ flip;
            if (flaw == FLAW_CHECKSUM) fb[26] = fb[26] ^ flip;
        end
        for (i = 0; i < len; i++) push_byte(fb[i], i == len - 1);
        frames_sent++;
        if (flaw == FLAW_NONE && len == 27) well_formed++;
    endtask

    // Receiver: a fresh random stall, none while quiet, before every result word.
    initial begin
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out with %0d results still outstanding.", pending);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int len;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        quiet       = 1'b0;
        bytes_sent  = 0;
        frames_sent = 0;
        well_formed = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames: payload extremes, each header byte wrong, bad checksum,
        // short, one-off lengths, overlong frames past the count saturation and noise.
        send_frame(27, FLAW_NONE, FILL_ZERO, 0);
        send_frame(27, FLAW_NONE, FILL_ONES, 0);
        send_frame(27, FLAW_NONE, FILL_EDGE, 0);
        send_frame(27, FLAW_CHECKSUM, FILL_RAND, 0);
        send_frame(27, FLAW_HEADER, FILL_RAND, 0);
        send_frame(27, FLAW_HEADER, FILL_RAND, 1);
        send_frame(27, FLAW_HEADER, FILL_RAND, 2);
        send_frame(1, FLAW_NONE, FILL_RAND, 0);
        send_frame(26, FLAW_NONE, FILL_RAND, 0);
        send_frame(28, FLAW_NONE, FILL_RAND, 0);
        send_frame(31, FLAW_NONE, FILL_RAND, 0);
        send_frame(40, FLAW_NONE, FILL_RAND, 0);
        send_frame(27, FLAW_NOISE, FILL_RAND, 0);
        send_frame(27, FLAW_NONE, FILL_RAND, 0);

        while (bytes_sent < BYTE_BUDGET) begin
            quiet = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_frame(27, FLAW_NONE, pick_fill(), 0);
                6: send_frame(27, FLAW_CHECKSUM, pick_fill(), 0);
                7: send_frame(27, FLAW_HEADER, pick_fill(), $urandom_range(0, 2));
                8: send_frame($urandom_range(1, 40), FLAW_NOISE, FILL_RAND, 0);
                default: begin
                    case ($urandom_range(0, 2))
                        0: len = 26;
                        1: len = 28;
                        default: len = $urandom_range(1, 40);
                    endcase
                    send_frame(len, FLAW_NONE, pick_fill(), 0);
                end
            endcase
        end
        quiet = 1'b0;
        i_s_tvalid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Drove %0d frames, %0d of them well formed, with random gaps and stalls.",
                 frames_sent, well_formed);
        $display("Checked %0d result words, %0d reported good.", results_seen, good_seen);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
